// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the CRC checked page reassembly block.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int PAGE_BYTES  = 16384;
    localparam int FRAME_BYTES = 255;
    localparam int PAGE_AW     = 14;
    localparam int FRAME_AW    = 8;

    localparam logic [7:0]  OPC_BEGIN  = 8'h01;
    localparam logic [7:0]  OPC_DATA   = 8'h02;
    localparam logic [7:0]  OPC_COMMIT = 8'h03;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [16:0] RX_SAT     = 17'h1FFFF;

    typedef enum logic [3:0] {
        ST_BEGIN_OK       = 4'd0,
        ST_BEGIN_SHORT    = 4'd1,
        ST_BAD_LENGTH     = 4'd2,
        ST_DATA_STORED    = 4'd3,
        ST_DATA_IGNORED   = 4'd4,
        ST_OUT_OF_RANGE   = 4'd5,
        ST_COMMIT_OK      = 4'd6,
        ST_COMMIT_IGNORED = 4'd7,
        ST_LEN_MISMATCH   = 4'd8,
        ST_CRC_MISMATCH   = 4'd9,
        ST_UNKNOWN_OPC    = 4'd10,
        ST_FRAME_LONG     = 4'd11,
        ST_READ_DONE      = 4'd12
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_COPY_RD,
        S_COPY_WR,
        S_CRC_RD,
        S_CRC_ACC,
        S_CRC_CHECK,
        S_READ,
        S_READ_DATA,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic init;
        logic step;
    } crc_ctl_t;

endpackage

// ===== rtl/cpr_ram.sv =====
// ----------------------------------------------------------------------------
// cpr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpr_crc16.sv =====
// ----------------------------------------------------------------------------
// cpr_crc16
// Reflected CRC-16 accumulator that folds in one byte per step.
// ----------------------------------------------------------------------------
module cpr_crc16 (
    input  logic              aclk,
    input  cpr_pkg::crc_ctl_t ctl,
    input  logic [7:0]        data,
    output logic [15:0]       crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] acc;

    always_comb begin
        acc = crc_reg ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ cpr_pkg::CRC_POLY) : (acc >> 1);
        end
        crc_next = crc_reg;
        if (ctl.init) begin
            crc_next = cpr_pkg::CRC_SEED;
        end else if (ctl.step) begin
            crc_next = acc;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// ===== rtl/crc_checked_page_reassembly.sv =====
// ----------------------------------------------------------------------------
// crc_checked_page_reassembly
// Reassembles a page from byte-serial downlink frames and checks its CRC.
// ----------------------------------------------------------------------------
// The slave channel carries one transaction per frame byte or page read.
// s_tuser selects a read, s_tlast marks the final byte of a frame. A frame
// byte that is not the last gives no result. A read passes through S_READ,
// S_READ_DATA and S_RESULT. The final byte of a frame passes through S_DISPATCH
// and S_RESULT for most outcomes; an accepted begin frame also sweeps the whole
// staging page in S_CLEAR, a stored data frame copies its payload through
// S_COPY_RD and S_COPY_WR per byte, and a commit with a matching length runs
// the CRC over the expected length through S_CRC_RD and S_CRC_ACC per byte,
// then S_CRC_CHECK, in the single CRC unit. A successful commit swaps the
// staging and live banks. Results go into an output register, so the block
// returns to accepting transactions while a result waits for m_tready; a further
// result waits until that register is free. Reset clears all control state,
// the live length and the armed transfer; no clearing pass runs at reset.
// ----------------------------------------------------------------------------
module crc_checked_page_reassembly (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // frame_byte[7:0], read_index[21:8], zero fill
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,  // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // read_byte[7:0], live_length[22:8], zero fill
    output logic [3:0]  m_tuser   // status[3:0]
);

    cpr_pkg::state_t  state_reg, state_next;
    cpr_pkg::status_t res_status_reg, res_status_next;
    logic [7:0]  res_byte_reg, res_byte_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  hdr_reg [5];
    logic [7:0]  hdr_next [5];
    logic [13:0] idx_reg, idx_next;
    logic [14:0] exp_len_reg, exp_len_next;
    logic [15:0] exp_crc_reg, exp_crc_next;
    logic [16:0] rx_reg, rx_next;
    logic        active_reg, active_next;
    logic [14:0] live_bytes_reg, live_bytes_next;
    logic        bank_reg, bank_next;
    logic [14:0] walk_reg, walk_next;
    logic [13:0] off_reg, off_next;
    logic [7:0]  n_reg, n_next;
    logic        m_valid_reg, m_valid_next;
    cpr_pkg::status_t m_status_reg, m_status_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic [14:0] m_len_reg, m_len_next;

    logic        accept;
    logic        f_we;
    logic [7:0]  f_raddr;
    logic [7:0]  f_rdata;
    logic        stg_we;
    logic [13:0] stg_waddr;
    logic [7:0]  stg_wdata;
    logic [13:0] stg_raddr;
    logic [7:0]  stg_rdata;
    logic [7:0]  live_rdata;
    logic [7:0]  rd0, rd1;
    cpr_pkg::crc_ctl_t crc_ctl;
    logic [15:0] crc;
    logic [15:0] hdr_word1, hdr_word2;
    logic [7:0]  n_calc;
    logic [16:0] end_calc;
    logic [17:0] rx_sum;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == cpr_pkg::S_IDLE);
    assign f_we     = accept && !s_tuser[0] && (count_reg < 9'(cpr_pkg::FRAME_BYTES));

    assign hdr_word1 = {hdr_reg[2], hdr_reg[1]};
    assign hdr_word2 = {hdr_reg[4], hdr_reg[3]};
    assign n_calc    = count_reg[7:0] - 8'd3;
    assign end_calc  = {1'b0, hdr_word1} + {9'b0, n_calc};
    assign rx_sum    = {1'b0, rx_reg} + {10'b0, n_calc};

    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        count_next      = count_reg;
        hdr_next        = hdr_reg;
        idx_next        = idx_reg;
        exp_len_next    = exp_len_reg;
        exp_crc_next    = exp_crc_reg;
        rx_next         = rx_reg;
        active_next     = active_reg;
        live_bytes_next = live_bytes_reg;
        bank_next       = bank_reg;
        walk_next       = walk_reg;
        off_next        = off_reg;
        n_next          = n_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_byte_next     = m_byte_reg;
        m_len_next      = m_len_reg;
        f_raddr         = 8'(8'd3 + walk_reg[7:0]);
        stg_we          = 1'b0;
        stg_waddr       = walk_reg[13:0];
        stg_wdata       = 8'h00;
        stg_raddr       = walk_reg[13:0];
        crc_ctl         = '0;

        case (state_reg)
            cpr_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0]) begin
                        idx_next   = s_tdata[21:8];
                        state_next = cpr_pkg::S_READ;
                    end else begin
                        if (count_reg < 9'(cpr_pkg::FRAME_BYTES)) begin
                            if (count_reg < 9'd5) begin
                                hdr_next[count_reg[2:0]] = s_tdata[7:0];
                            end
                            count_next = count_reg + 9'd1;
                        end else begin
                            count_next = 9'(cpr_pkg::FRAME_BYTES + 1);
                        end
                        if (s_tlast) begin
                            state_next = cpr_pkg::S_DISPATCH;
                        end
                    end
                end
            end
            cpr_pkg::S_DISPATCH: begin
                count_next    = 9'd0;
                res_byte_next = 8'h00;
                walk_next     = 15'd0;
                state_next    = cpr_pkg::S_RESULT;
                if (count_reg > 9'(cpr_pkg::FRAME_BYTES)) begin
                    res_status_next = cpr_pkg::ST_FRAME_LONG;
                end else begin
                    case (hdr_reg[0])
                        cpr_pkg::OPC_BEGIN: begin
                            if (count_reg < 9'd5) begin
                                res_status_next = cpr_pkg::ST_BEGIN_SHORT;
                            end else if (hdr_word1 == 16'd0 ||
                                         hdr_word1 > 16'(cpr_pkg::PAGE_BYTES)) begin
                                active_next     = 1'b0;
                                res_status_next = cpr_pkg::ST_BAD_LENGTH;
                            end else begin
                                exp_len_next    = hdr_word1[14:0];
                                exp_crc_next    = hdr_word2;
                                rx_next         = 17'd0;
                                active_next     = 1'b1;
                                res_status_next = cpr_pkg::ST_BEGIN_OK;
                                state_next      = cpr_pkg::S_CLEAR;
                            end
                        end
                        cpr_pkg::OPC_DATA: begin
                            if (!active_reg || count_reg < 9'd3) begin
                                res_status_next = cpr_pkg::ST_DATA_IGNORED;
                            end else if (end_calc > 17'(cpr_pkg::PAGE_BYTES)) begin
                                res_status_next = cpr_pkg::ST_OUT_OF_RANGE;
                            end else begin
                                rx_next = (rx_sum > {1'b0, cpr_pkg::RX_SAT}) ?
                                          cpr_pkg::RX_SAT : rx_sum[16:0];
                                off_next        = hdr_word1[13:0];
                                n_next          = n_calc;
                                res_status_next = cpr_pkg::ST_DATA_STORED;
                                if (n_calc != 8'd0) begin
                                    state_next = cpr_pkg::S_COPY_RD;
                                end
                            end
                        end
                        cpr_pkg::OPC_COMMIT: begin
                            if (!active_reg) begin
                                res_status_next = cpr_pkg::ST_COMMIT_IGNORED;
                            end else begin
                                active_next = 1'b0;
                                if (rx_reg != {2'b0, exp_len_reg}) begin
                                    res_status_next = cpr_pkg::ST_LEN_MISMATCH;
                                end else begin
                                    crc_ctl.init = 1'b1;
                                    state_next   = cpr_pkg::S_CRC_RD;
                                end
                            end
                        end
                        default: begin
                            res_status_next = cpr_pkg::ST_UNKNOWN_OPC;
                        end
                    endcase
                end
            end
            cpr_pkg::S_CLEAR: begin
                stg_we    = 1'b1;
                walk_next = walk_reg + 15'd1;
                if (walk_reg == 15'(cpr_pkg::PAGE_BYTES - 1)) begin
                    state_next = cpr_pkg::S_RESULT;
                end
            end
            cpr_pkg::S_COPY_RD: begin
                state_next = cpr_pkg::S_COPY_WR;
            end
            cpr_pkg::S_COPY_WR: begin
                stg_we     = 1'b1;
                stg_waddr  = off_reg + walk_reg[13:0];
                stg_wdata  = f_rdata;
                walk_next  = walk_reg + 15'd1;
                state_next = cpr_pkg::S_COPY_RD;
                if (walk_reg + 15'd1 == {7'b0, n_reg}) begin
                    state_next = cpr_pkg::S_RESULT;
                end
            end
            cpr_pkg::S_CRC_RD: begin
                state_next = cpr_pkg::S_CRC_ACC;
            end
            cpr_pkg::S_CRC_ACC: begin
                crc_ctl.step = 1'b1;
                walk_next    = walk_reg + 15'd1;
                state_next   = cpr_pkg::S_CRC_RD;
                if (walk_reg + 15'd1 == exp_len_reg) begin
                    state_next = cpr_pkg::S_CRC_CHECK;
                end
            end
            cpr_pkg::S_CRC_CHECK: begin
                state_next = cpr_pkg::S_RESULT;
                if (crc != exp_crc_reg) begin
                    res_status_next = cpr_pkg::ST_CRC_MISMATCH;
                end else begin
                    bank_next       = !bank_reg;
                    live_bytes_next = exp_len_reg;
                    res_status_next = cpr_pkg::ST_COMMIT_OK;
                end
            end
            cpr_pkg::S_READ: begin
                state_next = cpr_pkg::S_READ_DATA;
            end
            cpr_pkg::S_READ_DATA: begin
                res_byte_next   = ({1'b0, idx_reg} < live_bytes_reg) ? live_rdata : 8'h00;
                res_status_next = cpr_pkg::ST_READ_DONE;
                state_next      = cpr_pkg::S_RESULT;
            end
            cpr_pkg::S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_byte_next   = res_byte_reg;
                    m_len_next    = live_bytes_reg;
                    state_next    = cpr_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cpr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cpr_pkg::S_IDLE;
            count_reg      <= 9'd0;
            exp_len_reg    <= 15'd0;
            exp_crc_reg    <= 16'd0;
            rx_reg         <= 17'd0;
            active_reg     <= 1'b0;
            live_bytes_reg <= 15'd0;
            bank_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            exp_len_reg    <= exp_len_next;
            exp_crc_reg    <= exp_crc_next;
            rx_reg         <= rx_next;
            active_reg     <= active_next;
            live_bytes_reg <= live_bytes_next;
            bank_reg       <= bank_next;
            m_valid_reg    <= m_valid_next;
        end
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        hdr_reg        <= hdr_next;
        idx_reg        <= idx_next;
        walk_reg       <= walk_next;
        off_reg        <= off_next;
        n_reg          <= n_next;
        m_status_reg   <= m_status_next;
        m_byte_reg     <= m_byte_next;
        m_len_reg      <= m_len_next;
    end

    cpr_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (count_reg[7:0]),
        .wdata (s_tdata[7:0]),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    cpr_ram #(
        .WIDTH (8),
        .DEPTH (cpr_pkg::PAGE_BYTES)
    ) u_bank0_ram (
        .aclk  (aclk),
        .we    (stg_we && bank_reg),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (bank_reg ? stg_raddr : idx_reg),
        .rdata (rd0)
    );

    cpr_ram #(
        .WIDTH (8),
        .DEPTH (cpr_pkg::PAGE_BYTES)
    ) u_bank1_ram (
        .aclk  (aclk),
        .we    (stg_we && !bank_reg),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (bank_reg ? idx_reg : stg_raddr),
        .rdata (rd1)
    );

    assign stg_rdata  = bank_reg ? rd0 : rd1;
    assign live_rdata = bank_reg ? rd1 : rd0;

    cpr_crc16 u_crc (
        .aclk (aclk),
        .ctl  (crc_ctl),
        .data (stg_rdata),
        .crc  (crc)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_len_reg, m_byte_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== tb/sv/crc_checked_page_reassembly_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_page_reassembly_tb
// Self-checking testbench of the CRC checked page reassembly block.
// ----------------------------------------------------------------------------
// A short table of directed transactions is followed by randomized page
// transfers (begin, data chunks, commit with good or bad CRC and length),
// page reads and malformed frames. Every accepted transaction goes through a
// behavioral model of the block, and each result transaction is compared
// with the oldest predicted one. Sender and receiver idle at varying rates.
// ----------------------------------------------------------------------------
module crc_checked_page_reassembly_tb;

    localparam int CYCLE_LIMIT = 3000000;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic              op;
        logic [7:0]        fbyte;
        logic              last;
        logic [13:0]       ridx;
        logic              typed;
        cpr_pkg::status_t  t_status;
        logic [7:0]        t_rbyte;
        logic [14:0]       t_len;
    } stim_t;

    typedef struct {
        cpr_pkg::status_t  status;
        logic [7:0]        rbyte;
        logic [14:0]       len;
    } page_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    stim_t        stim[$];
    page_result_t pending_results[$];
    int           sp = 0;
    int           errors = 0;
    int           cycles = 0;
    int           hold_at;
    int           pause_at;
    int           stall_cnt = 0;
    bit           stall_done = 1'b0;
    int           begins_ok = 0;

    // Model state.
    logic [7:0]  frame_buf[256];
    int          frame_len;
    logic [7:0]  staging[cpr_pkg::PAGE_BYTES];
    logic [7:0]  live[cpr_pkg::PAGE_BYTES];
    int          live_len;
    int          exp_len;
    logic [15:0] exp_crc;
    int          rx_total;
    bit          armed;

    crc_checked_page_reassembly u_top (.*);

    always #1 aclk = ~aclk;

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        crc ^= {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ cpr_pkg::CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic cpr_pkg::status_t run_frame(int n);
        int          l;
        int          off;
        logic [15:0] crc;
        case (frame_buf[0])
            cpr_pkg::OPC_BEGIN: begin
                if (n < 5) return cpr_pkg::ST_BEGIN_SHORT;
                l = {frame_buf[2], frame_buf[1]};
                if (l == 0 || l > cpr_pkg::PAGE_BYTES) begin
                    armed = 1'b0;
                    return cpr_pkg::ST_BAD_LENGTH;
                end
                exp_len = l;
                exp_crc = {frame_buf[4], frame_buf[3]};
                foreach (staging[i]) staging[i] = 8'h00;
                rx_total = 0;
                armed = 1'b1;
                return cpr_pkg::ST_BEGIN_OK;
            end
            cpr_pkg::OPC_DATA: begin
                if (!armed || n < 3) return cpr_pkg::ST_DATA_IGNORED;
                off = {frame_buf[2], frame_buf[1]};
                if (off + n - 3 > cpr_pkg::PAGE_BYTES) return cpr_pkg::ST_OUT_OF_RANGE;
                for (int i = 0; i < n - 3; i++) staging[off + i] = frame_buf[3 + i];
                rx_total += n - 3;
                if (rx_total > cpr_pkg::RX_SAT) rx_total = cpr_pkg::RX_SAT;
                return cpr_pkg::ST_DATA_STORED;
            end
            cpr_pkg::OPC_COMMIT: begin
                if (!armed) return cpr_pkg::ST_COMMIT_IGNORED;
                armed = 1'b0;
                if (rx_total != exp_len) return cpr_pkg::ST_LEN_MISMATCH;
                crc = cpr_pkg::CRC_SEED;
                for (int i = 0; i < exp_len; i++) crc = crc16_step(crc, staging[i]);
                if (crc != exp_crc) return cpr_pkg::ST_CRC_MISMATCH;
                for (int i = 0; i < exp_len; i++) live[i] = staging[i];
                live_len = exp_len;
                return cpr_pkg::ST_COMMIT_OK;
            end
            default: return cpr_pkg::ST_UNKNOWN_OPC;
        endcase
    endfunction

    task automatic predict_transaction(stim_t s);
        page_result_t r;
        r.rbyte = 8'h00;
        if (s.op) begin
            if (s.ridx < live_len) r.rbyte = live[s.ridx];
            r.status = cpr_pkg::ST_READ_DONE;
        end else begin
            if (frame_len < cpr_pkg::FRAME_BYTES) begin
                frame_buf[frame_len] = s.fbyte;
                frame_len++;
            end else begin
                frame_len = cpr_pkg::FRAME_BYTES + 1;
            end
            if (!s.last) return;
            r.status = (frame_len > cpr_pkg::FRAME_BYTES) ? cpr_pkg::ST_FRAME_LONG :
                       run_frame(frame_len);
            frame_len = 0;
        end
        r.len = live_len[14:0];
        if (s.typed) begin
            r.status = s.t_status;
            r.rbyte  = s.t_rbyte;
            r.len    = s.t_len;
        end
        pending_results.push_back(r);
    endtask

    task automatic add_item(logic op, logic [7:0] b, logic last, logic [13:0] idx,
                            logic typed = 1'b0,
                            cpr_pkg::status_t st = cpr_pkg::ST_READ_DONE);
        stim_t s;
        s.op = op; s.fbyte = b; s.last = last; s.ridx = idx;
        s.typed = typed; s.t_status = st; s.t_rbyte = 8'h00; s.t_len = '0;
        stim.push_back(s);
    endtask

    task automatic add_frame(byte_q_t f);
        foreach (f[i]) add_item(1'b0, f[i], i == f.size() - 1, 14'($urandom));
    endtask

    task automatic add_read();
        logic [13:0] idx;
        idx = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(40));
        add_item(1'b1, 8'($urandom), 1'($urandom), idx);
    endtask

    task automatic add_transfer(int l, bit good_crc, bit full_count);
        logic [7:0]  content[$];
        logic [15:0] crc;
        byte_q_t     f;
        int          off;
        int          n;
        crc = cpr_pkg::CRC_SEED;
        for (int i = 0; i < l; i++) begin
            content.push_back(8'($urandom));
            crc = crc16_step(crc, content[i]);
        end
        if (!good_crc) crc ^= 16'(1 << $urandom_range(15));
        f = {cpr_pkg::OPC_BEGIN, 8'(l), 8'(l >> 8), crc[7:0], crc[15:8]};
        if ($urandom_range(3) == 0) f.push_back(8'($urandom));
        add_frame(f);
        begins_ok++;
        off = 0;
        while (off < l) begin
            n = $urandom_range(1, (l - off < 20) ? l - off : 20);
            if (!full_count && off + n >= l) break;
            f = {cpr_pkg::OPC_DATA, 8'(off), 8'(off >> 8)};
            for (int i = 0; i < n; i++) f.push_back(content[off + i]);
            add_frame(f);
            if ($urandom_range(7) == 0) add_read();
            off += n;
        end
        if ($urandom_range(5) == 0) begin
            f = {cpr_pkg::OPC_DATA, 8'h00, 8'h00};
            add_frame(f);
        end
        f = {cpr_pkg::OPC_COMMIT};
        if ($urandom_range(4) == 0) f.push_back(8'($urandom));
        add_frame(f);
        for (int i = $urandom_range(3); i > 0; i--) add_read();
    endtask

    task automatic add_noise();
        byte_q_t f;
        int      n;
        case ($urandom_range(5))
            0: begin
                f = {8'($urandom_range(4, 255))};
                if ($urandom_range(1)) f[0] = 8'h00;
                for (int i = $urandom_range(5); i > 0; i--) f.push_back(8'($urandom));
            end
            1: begin
                n = $urandom_range(16383);
                f = {cpr_pkg::OPC_DATA, 8'(n), 8'(n >> 8)};
                for (int i = $urandom_range(1, 6); i > 0; i--) f.push_back(8'($urandom));
            end
            2: f = {cpr_pkg::OPC_DATA, 8'($urandom)};
            3: begin
                f = {cpr_pkg::OPC_BEGIN};
                for (int i = $urandom_range(3); i > 0; i--) f.push_back(8'($urandom));
            end
            4: f = {cpr_pkg::OPC_BEGIN, 8'h00, 8'h00, 8'($urandom), 8'($urandom)};
            default: f = {cpr_pkg::OPC_COMMIT};
        endcase
        add_frame(f);
    endtask

    task automatic build_stimulus();
        byte_q_t f;
        // Directed: extremes, every opcode and several error outcomes.
        add_item(1'b1, 8'h00, 1'b0, 14'h0000, 1'b1, cpr_pkg::ST_READ_DONE);
        add_item(1'b1, 8'hFF, 1'b1, 14'h3FFF, 1'b1, cpr_pkg::ST_READ_DONE);
        add_item(1'b0, cpr_pkg::OPC_COMMIT, 1'b1, 14'h3FFF, 1'b1,
                 cpr_pkg::ST_COMMIT_IGNORED);
        add_item(1'b0, cpr_pkg::OPC_DATA, 1'b1, 14'h0000, 1'b1,
                 cpr_pkg::ST_DATA_IGNORED);
        add_item(1'b0, 8'hFF, 1'b1, 14'h0000, 1'b1, cpr_pkg::ST_UNKNOWN_OPC);
        add_item(1'b0, 8'h00, 1'b1, 14'h0000, 1'b1, cpr_pkg::ST_UNKNOWN_OPC);
        add_item(1'b0, cpr_pkg::OPC_BEGIN, 1'b0, 14'h0000);
        add_item(1'b0, 8'h00, 1'b1, 14'h0000, 1'b1, cpr_pkg::ST_BEGIN_SHORT);
        add_item(1'b0, cpr_pkg::OPC_BEGIN, 1'b0, 14'h0000);
        repeat (3) add_item(1'b0, 8'h00, 1'b0, 14'h0000);
        add_item(1'b0, 8'h00, 1'b1, 14'h0000, 1'b1, cpr_pkg::ST_BAD_LENGTH);
        add_item(1'b0, cpr_pkg::OPC_BEGIN, 1'b0, 14'h0000);
        add_item(1'b0, 8'h01, 1'b0, 14'h0000);
        add_item(1'b0, 8'h40, 1'b0, 14'h0000);
        add_item(1'b0, 8'hFF, 1'b0, 14'h0000);
        add_item(1'b0, 8'hFF, 1'b1, 14'h0000, 1'b1, cpr_pkg::ST_BAD_LENGTH);
        add_transfer(1, 1'b1, 1'b1);
        add_item(1'b1, 8'h00, 1'b0, 14'h0000);

        // Largest page: an in-range write at the very end, one past it, commit.
        f = {cpr_pkg::OPC_BEGIN, 8'h00, 8'h40, 8'h00, 8'h00};
        add_frame(f);
        begins_ok++;
        f = {cpr_pkg::OPC_DATA, 8'hFC, 8'h3F, 8'h11, 8'h22, 8'h33, 8'hFF};
        add_frame(f);
        f = {cpr_pkg::OPC_DATA, 8'hFD, 8'h3F, 8'h11, 8'h22, 8'h33, 8'h44};
        add_frame(f);
        f = {cpr_pkg::OPC_COMMIT};
        add_frame(f);

        while (stim.size() < 980) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    if (begins_ok < 30)
                        add_transfer($urandom_range(1, 24), $urandom_range(3) != 0,
                                     $urandom_range(5) != 0);
                    else
                        add_noise();
                end
                11, 12, 13: for (int i = $urandom_range(1, 6); i > 0; i--) add_read();
                14: if (stim.size() % 3 == 0) begin
                    f = {};
                    for (int i = 0; i < 260; i++) f.push_back(8'($urandom));
                    add_frame(f);
                end
                default: add_noise();
            endcase
        end
        add_read();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic int phase_of(int idx);
        return (idx * 4) / (stim.size() + 1);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sender.
    always @(posedge aclk) begin
        int  ph;
        bit  fire;
        bit  idle;
        fire = s_tvalid && s_tready;
        if (aresetn) begin
            if (fire) begin
                predict_transaction(stim[sp]);
                sp = sp + 1;
            end
            ph = phase_of(sp);
            idle = (ph == 1) ? ($urandom_range(99) < 66) :
                   (ph == 3) ? ($urandom_range(99) < 31) : 1'b0;
            if (sp == pause_at && pending_results.size() != 0) idle = 1'b1;
            if (s_tvalid && !fire) begin
            end else if (sp < stim.size() && !idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, stim[sp].ridx, stim[sp].fbyte};
                s_tlast  <= stim[sp].last;
                s_tuser  <= stim[sp].op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off while the sender keeps offering.
    always @(posedge aclk) begin
        int ph;
        ph = phase_of(sp);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else if (!stall_done && sp >= hold_at) begin
            stall_done <= 1'b1;
            stall_cnt  <= 600;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= (ph == 2) ? ($urandom_range(99) >= 66) :
                        (ph == 3) ? ($urandom_range(99) >= 31) : 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        page_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_tuser, -1);
            end else begin
                e = pending_results.pop_front();
                if (m_tuser != e.status) report_mismatch("status", m_tuser, e.status);
                if (m_tdata[7:0] != e.rbyte) report_mismatch("read_byte", m_tdata[7:0], e.rbyte);
                if (m_tdata[22:8] != e.len) report_mismatch("live_length", m_tdata[22:8], e.len);
                if (m_tdata[23] !== 1'b0) report_mismatch("fill bit", m_tdata[23], 0);
            end
        end
    end

    initial begin
        frame_len = 0;
        live_len  = 0;
        exp_len   = 0;
        exp_crc   = '0;
        rx_total  = 0;
        armed     = 1'b0;
        foreach (staging[i]) staging[i] = 8'h00;
        foreach (live[i]) live[i] = 8'h00;
        build_stimulus();
        hold_at  = stim.size() / 8;
        pause_at = stim.size() / 2;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (sp == stim.size() && pending_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
